>>> rtl/msp_pkg.sv
// Package for the motor speed PID block: field widths, register indexes,
// reset values and fixed thresholds. No dependencies.
package msp_pkg;

  localparam int SPEED_W        = 16;
  localparam int GAIN_W         = 16;
  localparam int DUTY_W         = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int ERR_W          = 18;
  localparam int SUM_W          = 32;
  localparam int GAIN_FRAC_BITS = 8;

  localparam logic [SPEED_W:0]  SLOW_SPEED    = 17'd80;
  localparam logic [DUTY_W-1:0] INCR_I_CUTOFF = 16'd11000;

  localparam logic              MODE_RST        = 1'b1;
  localparam logic [GAIN_W-1:0] KP_RST          = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RST          = 16'd0;
  localparam logic [GAIN_W-1:0] KD_RST          = 16'd0;
  localparam logic [DUTY_W-1:0] OUT_MAX_RST     = 16'd25000;
  localparam logic [DUTY_W-1:0] START_FLOOR_RST = 16'd2600;
  localparam logic [DUTY_W-1:0] INTEG_LIM_RST   = 16'd4000;
  localparam logic [DUTY_W-1:0] SLOW_CAP_RST    = 16'd8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_KP          = 3'd1,
    CFG_KI          = 3'd2,
    CFG_KD          = 3'd3,
    CFG_OUT_MAX     = 3'd4,
    CFG_START_FLOOR = 3'd5,
    CFG_INTEG_LIM   = 3'd6,
    CFG_SLOW_CAP    = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    MODE_INCR = 1'b0,
    MODE_POS  = 1'b1
  } pid_mode_t;

endpackage

>>> rtl/msp_if.sv
// Valid/ready channel interfaces for the motor speed PID block.
// Depends on msp_pkg for field widths.
interface msp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [msp_pkg::SPEED_W-1:0]  target_speed;
  logic signed [msp_pkg::SPEED_W-1:0]  encoder_count;

  modport source (output valid, output target_speed, output encoder_count, input ready);
  modport sink   (input valid, input target_speed, input encoder_count, output ready);
endinterface

interface msp_out_if;
  logic                          valid;
  logic                          ready;
  logic [msp_pkg::DUTY_W-1:0]    duty;
  logic                          direction;
  logic                          stopped;

  modport source (output valid, output duty, output direction, output stopped, input ready);
  modport sink   (input valid, input duty, input direction, input stopped, output ready);
endinterface

>>> rtl/motor_speed_pid.sv
// Top level of the motor speed PID block: input stage, PID datapath and
// result register. Depends on msp_pkg and the channel interfaces in msp_if.
//
// One motor channel's speed regulator. Each input transaction (signed target
// speed, encoder count for the tick) yields exactly one result transaction
// (duty, direction, stopped). A new transaction is taken every clock cycle
// unless the result register holds a result that is not yet taken; the
// input stage holds the accepted transaction and its result is then loaded
// into the output register, where it stays until it is taken. The
// cycle time is set by the single pass from the input stage through the
// three gain multipliers, the adder and the output clamp back into the
// drive level register, which the next transaction reads. Gains are
// unsigned Q8.8 with floor rounding. Configuration writes must only occur
// while no transaction is in flight.
module motor_speed_pid (
  input  logic                              clk,
  input  logic                              rst_n,
  msp_in_if.sink                            in_chan,
  msp_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  msp_pkg::cfg_idx_t                 cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import msp_pkg::*;

  // configuration
  pid_mode_t          mode_r;
  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [DUTY_W-1:0]  out_max_r, start_floor_r, integ_lim_r, slow_cap_r;

  // controller state
  logic [DUTY_W-1:0]        drive_r, drive_nxt;
  logic signed [ERR_W-1:0]  integ_r, integ_nxt;
  logic signed [ERR_W-1:0]  e1_r, e1_nxt;
  logic signed [ERR_W-1:0]  e2_r, e2_nxt;

  // input stage
  logic                       stage_valid_r;
  logic signed [SPEED_W-1:0]  tgt_r, enc_r;

  // result register
  logic               out_valid_r;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic               dir_r, dir_nxt;
  logic               stopped_r, stopped_nxt;

  logic advance;

  // datapath
  logic                      fwd;
  logic [SPEED_W:0]          t_mag;
  logic signed [SPEED_W:0]   meas;
  logic signed [ERR_W-1:0]   e0;
  logic signed [ERR_W:0]     d1;
  logic signed [ERR_W+1:0]   d2;
  logic [DUTY_W-1:0]         lvl_floor, lvl_base;
  logic signed [ERR_W:0]     kp_op;
  logic signed [ERR_W+1:0]   kd_op;
  logic signed [GAIN_W+ERR_W+1:0] kp_prod;
  logic signed [GAIN_W+ERR_W:0]   ki_prod;
  logic signed [GAIN_W+ERR_W+2:0] kd_prod;
  logic signed [SUM_W-1:0]   kp_term, ki_term, kd_term;
  logic signed [SUM_W-1:0]   integ_pre, integ_lim, integ_clamped;
  logic signed [SUM_W-1:0]   lvl_new;

  assign advance       = stage_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !stage_valid_r || advance;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.duty      = duty_r;
  assign out_chan.direction = dir_r;
  assign out_chan.stopped   = stopped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= pid_mode_t'(MODE_RST);
      kp_r          <= KP_RST;
      ki_r          <= KI_RST;
      kd_r          <= KD_RST;
      out_max_r     <= OUT_MAX_RST;
      start_floor_r <= START_FLOOR_RST;
      integ_lim_r   <= INTEG_LIM_RST;
      slow_cap_r    <= SLOW_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:        mode_r        <= pid_mode_t'(cfg_data[0]);
        CFG_KP:          kp_r          <= cfg_data;
        CFG_KI:          ki_r          <= cfg_data;
        CFG_KD:          kd_r          <= cfg_data;
        CFG_OUT_MAX:     out_max_r     <= cfg_data;
        CFG_START_FLOOR: start_floor_r <= cfg_data;
        CFG_INTEG_LIM:   integ_lim_r   <= cfg_data;
        CFG_SLOW_CAP:    slow_cap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      stage_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      tgt_r <= in_chan.target_speed;
      enc_r <= in_chan.encoder_count;
    end
  end

  // direction and magnitude; the most negative target maps to 32768
  always_comb begin
    fwd   = !tgt_r[SPEED_W-1];
    t_mag = fwd ? {1'b0, tgt_r} : ((SPEED_W+1)'(0) - {tgt_r[SPEED_W-1], tgt_r});
    meas  = fwd ? {enc_r[SPEED_W-1], enc_r}
                : -$signed({enc_r[SPEED_W-1], enc_r});
    e0    = $signed({1'b0, t_mag}) - ERR_W'(meas);
    d1    = (ERR_W+1)'(e0) - (ERR_W+1)'(e1_r);
    d2    = (ERR_W+2)'(e0) - ((ERR_W+2)'(e1_r) <<< 1) + (ERR_W+2)'(e2_r);
  end

  always_comb begin
    lvl_floor = (drive_r < start_floor_r) ? start_floor_r : drive_r;
    lvl_base  = (t_mag < SLOW_SPEED && lvl_floor > slow_cap_r) ? slow_cap_r : lvl_floor;
  end

  // one multiplier per gain; the Kp and Kd operands depend on the mode
  always_comb begin
    kp_op   = (mode_r == MODE_POS) ? (ERR_W+1)'(e0) : d1;
    kd_op   = (mode_r == MODE_POS) ? (ERR_W+2)'(d1) : d2;
    kp_prod = $signed({1'b0, kp_r}) * kp_op;
    ki_prod = $signed({1'b0, ki_r}) * e0;
    kd_prod = $signed({1'b0, kd_r}) * kd_op;
    kp_term = SUM_W'(kp_prod >>> GAIN_FRAC_BITS);
    ki_term = SUM_W'(ki_prod >>> GAIN_FRAC_BITS);
    kd_term = SUM_W'(kd_prod >>> GAIN_FRAC_BITS);
  end

  always_comb begin
    integ_lim = $signed({{(SUM_W-DUTY_W){1'b0}}, integ_lim_r});
    integ_pre = SUM_W'(integ_r) + ki_term;
    priority if (integ_pre > integ_lim) begin
      integ_clamped = integ_lim;
    end else if (integ_pre < -integ_lim) begin
      integ_clamped = -integ_lim;
    end else begin
      integ_clamped = integ_pre;
    end

    if (mode_r == MODE_POS) begin
      lvl_new = kp_term + integ_clamped + kd_term;
    end else begin
      lvl_new = $signed({{(SUM_W-DUTY_W){1'b0}}, lvl_base}) + kp_term + kd_term
              + ((lvl_base < INCR_I_CUTOFF) ? ki_term : SUM_W'(0));
    end
  end

  always_comb begin
    drive_nxt   = drive_r;
    integ_nxt   = integ_r;
    e1_nxt      = e1_r;
    e2_nxt      = e2_r;
    duty_nxt    = duty_r;
    dir_nxt     = dir_r;
    stopped_nxt = stopped_r;
    if (t_mag == '0) begin
      drive_nxt   = '0;
      integ_nxt   = '0;
      e1_nxt      = '0;
      e2_nxt      = '0;
      duty_nxt    = '0;
      dir_nxt     = 1'b1;
      stopped_nxt = 1'b1;
    end else begin
      priority if (lvl_new < 0) begin
        drive_nxt = '0;
      end else if (lvl_new > $signed({{(SUM_W-DUTY_W){1'b0}}, out_max_r})) begin
        drive_nxt = out_max_r;
      end else begin
        drive_nxt = lvl_new[DUTY_W-1:0];
      end
      if (mode_r == MODE_POS) begin
        integ_nxt = ERR_W'(integ_clamped);
      end
      e2_nxt      = e1_r;
      e1_nxt      = e0;
      duty_nxt    = drive_nxt;
      dir_nxt     = fwd;
      stopped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r     <= '0;
      integ_r     <= '0;
      e1_r        <= '0;
      e2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        drive_r     <= drive_nxt;
        integ_r     <= integ_nxt;
        e1_r        <= e1_nxt;
        e2_r        <= e2_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_r    <= duty_nxt;
      dir_r     <= dir_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule
